// ===== sv/cdrbg_pkg.sv =====
// Package for the ChaCha20 random generator: request codes, queue entry type,
// ChaCha constants. No dependencies.
package cdrbg_pkg;
  localparam logic [1:0] REQ_INIT    = 2'd0;
  localparam logic [1:0] REQ_RESEED  = 2'd1;
  localparam logic [1:0] REQ_ADDL    = 2'd2;
  localparam logic [1:0] REQ_STREAM  = 2'd3;

  localparam logic [2:0] CFG_KEY_W0     = 3'd0;
  localparam logic [2:0] CFG_KEY_W1     = 3'd1;
  localparam logic [2:0] CFG_KEY_W2     = 3'd2;
  localparam logic [2:0] CFG_KEY_W3     = 3'd3;
  localparam logic [2:0] CFG_NONCE_LOW  = 3'd4;
  localparam logic [2:0] CFG_NONCE_HIGH = 3'd5;

  localparam int SEED_BYTES = 44;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  // Classified request as it travels from front to back.
  typedef struct packed {
    logic [1:0]  req;
    logic [31:0] word;
    logic [5:0]  pos;
    logic        last;
    logic [3:0]  count;
  } cmd_t;

  typedef logic [31:0] word_t;
endpackage

// ===== sv/cdrbg_if.sv =====
// Valid/ready channel interfaces for request and result transactions.
// Depends on nothing.
interface cdrbg_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] word_in;
  logic [5:0]  position;
  logic        last;
  logic [3:0]  byte_count;
  modport source(output valid, req_type, word_in, position, last, byte_count, input ready);
  modport sink(input valid, req_type, word_in, position, last, byte_count, output ready);
endinterface

interface cdrbg_res_if;
  logic        valid;
  logic        ready;
  logic [63:0] rand_out;
  logic [3:0]  out_count;
  logic        done_res;
  modport source(output valid, rand_out, out_count, done_res, input ready);
  modport sink(input valid, rand_out, out_count, done_res, output ready);
endinterface

// ===== sv/cdrbg_front.sv =====
// Front end: accepts requests, saturates counts and additional-byte positions,
// and holds them in a two-entry queue for the back end. Uses cdrbg_pkg.
module cdrbg_front #(
  parameter int MAX_STREAM_BYTES = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  cdrbg_req_if.sink            in_ch,
  output cdrbg_pkg::cmd_t      cmd,
  output logic                 cmd_valid,
  input  logic                 cmd_take
);
  import cdrbg_pkg::*;

  cmd_t       q_r [2];
  logic       rd_r, wr_r;
  logic [1:0] fill_r;
  cmd_t       c;
  logic       push;

  assign in_ch.ready = (fill_r != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign cmd = q_r[rd_r];
  assign cmd_valid = (fill_r != 2'd0);

  // Clamp byte count, and position of additional bytes, as the request enters.
  always_comb begin
    c.req = in_ch.req_type;
    c.word = in_ch.word_in;
    c.last = in_ch.last;
    c.pos = in_ch.position;
    if (in_ch.req_type == REQ_ADDL && in_ch.position > 6'(SEED_BYTES - 1))
      c.pos = 6'(SEED_BYTES - 1);
    c.count = (in_ch.byte_count > 4'(MAX_STREAM_BYTES)) ? 4'(MAX_STREAM_BYTES)
                                                         : in_ch.byte_count;
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= c;
    if (!rst_n) begin
      rd_r <= 1'b0;
      wr_r <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (cmd_take) rd_r <= ~rd_r;
      fill_r <= fill_r + {1'b0, push} - {1'b0, cmd_take};
    end
  end
endmodule

// ===== sv/cdrbg_core.sv =====
// ChaCha20 block core: one quarter round per cycle over a 16-word state,
// then the feed-forward add. Uses cdrbg_pkg.
module cdrbg_core #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  cdrbg_pkg::word_t     key [8],
  input  cdrbg_pkg::word_t     nonce [3],
  input  cdrbg_pkg::word_t     ctr,
  output logic                 busy,
  output logic                 finish,
  output cdrbg_pkg::word_t     blk [16]
);
  import cdrbg_pkg::*;

  localparam int STEPS = DOUBLE_ROUNDS * 8;
  localparam int SW = $clog2(STEPS + 1);

  word_t         st_r [16];
  word_t         init_r [16];
  logic [SW-1:0] step_r;
  logic          run_r, fin_r;
  logic [3:0]    ia, ib, ic, id;
  word_t         a0, b0, c0, d0, a1, b1, c1, d1, a2, b2, c2, d2;

  function automatic word_t rotl(word_t v, int s);
    rotl = (v << s) | (v >> (32 - s));
  endfunction

  // Lane selection: column rounds then diagonal rounds.
  always_comb begin
    logic [1:0] l;
    l = step_r[1:0];
    ia = {2'b00, l};
    if (!step_r[2]) begin
      ib = {2'b01, l};
      ic = {2'b10, l};
      id = {2'b11, l};
    end else begin
      ib = {2'b01, 2'(l + 2'd1)};
      ic = {2'b10, 2'(l + 2'd2)};
      id = {2'b11, 2'(l + 2'd3)};
    end
    a0 = st_r[ia] + st_r[ib];
    d0 = rotl(st_r[id] ^ a0, 16);
    c0 = st_r[ic] + d0;
    b0 = rotl(st_r[ib] ^ c0, 12);
    a1 = a0 + b0;
    d1 = rotl(d0 ^ a1, 8);
    c1 = c0 + d1;
    b1 = rotl(b0 ^ c1, 7);
    a2 = a1; b2 = b1; c2 = c1; d2 = d1;
  end

  assign busy = run_r;
  assign finish = fin_r;

  always_comb begin
    for (int i = 0; i < 16; i++) blk[i] = st_r[i] + init_r[i];
  end

  always_ff @(posedge clk) begin
    if (start) begin
      init_r[0] <= SIGMA0; init_r[1] <= SIGMA1;
      init_r[2] <= SIGMA2; init_r[3] <= SIGMA3;
      st_r[0] <= SIGMA0; st_r[1] <= SIGMA1;
      st_r[2] <= SIGMA2; st_r[3] <= SIGMA3;
      for (int i = 0; i < 8; i++) begin
        init_r[4 + i] <= key[i];
        st_r[4 + i] <= key[i];
      end
      init_r[12] <= ctr;
      st_r[12] <= ctr;
      for (int i = 0; i < 3; i++) begin
        init_r[13 + i] <= nonce[i];
        st_r[13 + i] <= nonce[i];
      end
    end else if (run_r) begin
      st_r[ia] <= a2; st_r[ib] <= b2; st_r[ic] <= c2; st_r[id] <= d2;
    end
    if (!rst_n) begin
      run_r <= 1'b0;
      fin_r <= 1'b0;
      step_r <= '0;
    end else begin
      fin_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        step_r <= '0;
      end else if (run_r) begin
        if (step_r == SW'(STEPS - 1)) begin
          run_r <= 1'b0;
          fin_r <= 1'b1;
        end
        step_r <= step_r + 1'b1;
      end
    end
  end
endmodule

// ===== sv/cdrbg_back.sv =====
// Back end: executes queued requests on the key, nonce, counter and keystream
// buffer, drives the core and the result register. Uses cdrbg_pkg, cdrbg_core.
module cdrbg_back #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cdrbg_pkg::cmd_t      cmd,
  input  logic                 cmd_valid,
  output logic                 cmd_take,
  input  logic [63:0]          seed_r [6],
  cdrbg_res_if.source          out_ch
);
  import cdrbg_pkg::*;

  localparam int SEED_WORDS = SEED_BYTES / 4;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_STREAM = 3'd1;
  localparam logic [2:0] S_REKEY  = 3'd2;
  localparam logic [2:0] S_MIX    = 3'd3;
  localparam logic [2:0] S_WAIT   = 3'd4;
  localparam logic [2:0] S_RESULT = 3'd5;

  logic [2:0]  state_r;
  word_t       key_r [8];
  word_t       nonce_r [3];
  word_t       ctr_r;
  word_t       blkw_r [16];
  logic [6:0]  rd_idx_r;
  word_t       addl_w_r [SEED_WORDS];
  word_t       seed_w_r [SEED_WORDS];
  logic [5:0]  cnt_r;
  logic [5:0]  len_r, mod_r;
  logic [3:0]  want_r;
  logic        rekey_after_r;
  logic [63:0] rand_r;
  logic [3:0]  outc_r;
  logic        done_r;
  logic        res_valid_r;
  logic        core_start, core_busy, core_fin;
  word_t       blk [16];
  logic [7:0]  cur_byte;
  logic [7:0]  addl_byte;
  logic [5:0]  wi;

  cdrbg_core #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_core (
    .clk, .rst_n, .start(core_start), .key(key_r), .nonce(nonce_r), .ctr(ctr_r),
    .busy(core_busy), .finish(core_fin), .blk(blk)
  );

  assign out_ch.valid = res_valid_r;
  assign out_ch.rand_out = rand_r;
  assign out_ch.out_count = outc_r;
  assign out_ch.done_res = done_r;

  assign cmd_take = (state_r == S_IDLE) && cmd_valid && !res_valid_r;
  // Keystream and additional bytes are held as little-endian 32-bit words.
  assign cur_byte = blkw_r[rd_idx_r[5:2]][8 * rd_idx_r[1:0] +: 8];
  assign addl_byte = addl_w_r[mod_r[5:2]][8 * mod_r[1:0] +: 8];
  assign wi = cnt_r >> 2;
  // A block is needed when the buffer is empty and the core is not running.
  assign core_start = (state_r == S_STREAM || state_r == S_REKEY) &&
                      rd_idx_r[6] && !core_busy && !core_fin &&
                      ((state_r == S_STREAM) ? (cnt_r[3:0] != want_r)
                                             : (cnt_r != 6'(SEED_BYTES)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      res_valid_r <= 1'b0;
      rd_idx_r <= 7'd64;
      ctr_r <= '0;
      for (int i = 0; i < 8; i++) key_r[i] <= '0;
      for (int i = 0; i < 3; i++) nonce_r[i] <= '0;
    end else begin
      if (res_valid_r && out_ch.ready) res_valid_r <= 1'b0;
      // A finished block refills the buffer.
      if (core_fin) begin
        for (int i = 0; i < 16; i++) blkw_r[i] <= blk[i];
        rd_idx_r <= '0;
        ctr_r <= ctr_r + 32'd1;
      end
      unique case (state_r)
        S_IDLE: begin
          if (cmd_take) begin
            rand_r <= '0;
            outc_r <= '0;
            done_r <= 1'b0;
            cnt_r <= '0;
            unique case (cmd.req)
              REQ_INIT: begin
                for (int i = 0; i < 4; i++) begin
                  key_r[2 * i] <= seed_r[i][31:0];
                  key_r[2 * i + 1] <= seed_r[i][63:32];
                end
                nonce_r[0] <= seed_r[4][31:0];
                nonce_r[1] <= seed_r[4][63:32];
                nonce_r[2] <= seed_r[5][31:0];
                ctr_r <= '0;
                rd_idx_r <= 7'd64;
                done_r <= 1'b1;
                state_r <= S_REKEY;
              end
              REQ_RESEED: begin
                if (cmd.pos < 6'd8) key_r[cmd.pos[2:0]] <= key_r[cmd.pos[2:0]] ^ cmd.word;
                else if (cmd.pos < 6'd11)
                  nonce_r[2'(cmd.pos - 6'd8)] <= nonce_r[2'(cmd.pos - 6'd8)] ^ cmd.word;
                if (cmd.last) begin
                  ctr_r <= '0;
                  rd_idx_r <= 7'd64;
                  done_r <= 1'b1;
                  state_r <= S_WAIT;
                end else state_r <= S_RESULT;
              end
              REQ_ADDL: begin
                addl_w_r[cmd.pos[5:2]][8 * cmd.pos[1:0] +: 8] <= cmd.word[7:0];
                if (cmd.last) begin
                  len_r <= cmd.pos + 6'd1;
                  mod_r <= '0;
                  done_r <= 1'b1;
                  state_r <= S_MIX;
                end else state_r <= S_RESULT;
              end
              default: begin
                want_r <= cmd.count;
                rekey_after_r <= cmd.last;
                done_r <= 1'b1;
                outc_r <= cmd.count;
                state_r <= S_STREAM;
              end
            endcase
          end
        end
        // Reseed XOR must land before the rekey reads the key.
        S_WAIT: state_r <= S_REKEY;
        S_STREAM: begin
          if (cnt_r[3:0] == want_r) begin
            cnt_r <= '0;
            state_r <= rekey_after_r ? S_REKEY : S_RESULT;
          end else if (!rd_idx_r[6] && !core_fin) begin
            rand_r[8 * cnt_r[2:0] +: 8] <= cur_byte;
            rd_idx_r <= rd_idx_r + 7'd1;
            cnt_r <= cnt_r + 6'd1;
          end
        end
        S_REKEY: begin
          if (cnt_r == 6'(SEED_BYTES)) begin
            for (int i = 0; i < 8; i++) key_r[i] <= seed_w_r[i];
            for (int i = 0; i < 3; i++) nonce_r[i] <= seed_w_r[8 + i];
            ctr_r <= '0;
            rd_idx_r <= 7'd64;
            state_r <= S_RESULT;
          end else if (!rd_idx_r[6] && !core_fin) begin
            seed_w_r[cnt_r[5:2]][8 * cnt_r[1:0] +: 8] <= cur_byte;
            rd_idx_r <= rd_idx_r + 7'd1;
            cnt_r <= cnt_r + 6'd1;
          end
        end
        // One seed byte per cycle XORed with the additional byte at i mod len.
        S_MIX: begin
          if (cnt_r == 6'(SEED_BYTES)) begin
            rd_idx_r <= 7'd64;
            state_r <= S_RESULT;
          end else begin
            if (wi < 6'd8)
              key_r[wi[2:0]][8 * cnt_r[1:0] +: 8] <=
                key_r[wi[2:0]][8 * cnt_r[1:0] +: 8] ^ addl_byte;
            else
              nonce_r[2'(wi - 6'd8)][8 * cnt_r[1:0] +: 8] <=
                nonce_r[2'(wi - 6'd8)][8 * cnt_r[1:0] +: 8] ^ addl_byte;
            mod_r <= (mod_r + 6'd1 == len_r) ? 6'd0 : mod_r + 6'd1;
            cnt_r <= cnt_r + 6'd1;
          end
        end
        S_RESULT: begin
          res_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== sv/chacha20_drbg_generator.sv =====
// Top level of the ChaCha20 random generator: configuration registers, front
// end and back end. Uses cdrbg_pkg, cdrbg_if, cdrbg_front, cdrbg_back.
//
// Every request transaction gives one result transaction. Requests queue in a
// two-entry buffer while the back end works one at a time. Non-final reseed
// words and additional bytes are answered directly; a final additional byte
// mixes 44 bytes into the key and nonce (one key byte per cycle); a stream
// reads its bytes from the buffer and draws a new block whenever the buffer
// runs empty (one quarter round per cycle in the block core). A rekey reads
// 44 bytes, one per cycle while the buffer holds bytes, and draws at most one
// block, since fewer than 44 buffered bytes are always topped up by a single
// 64-byte block.
// Configuration is written through cfg_we, cfg_index and cfg_data.
module chacha20_drbg_generator #(
  parameter int DOUBLE_ROUNDS = 10,
  parameter int MAX_STREAM_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  cdrbg_req_if.sink   in_ch,
  cdrbg_res_if.source out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import cdrbg_pkg::*;

  logic [63:0] seed_r [6];
  cmd_t        cmd;
  logic        cmd_valid, cmd_take;

  // Seed registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) seed_r[i] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_W0:     seed_r[0] <= cfg_data;
        CFG_KEY_W1:     seed_r[1] <= cfg_data;
        CFG_KEY_W2:     seed_r[2] <= cfg_data;
        CFG_KEY_W3:     seed_r[3] <= cfg_data;
        CFG_NONCE_LOW:  seed_r[4] <= cfg_data;
        CFG_NONCE_HIGH: seed_r[5] <= {32'd0, cfg_data[31:0]};
        default: ;
      endcase
    end
  end

  cdrbg_front #(.MAX_STREAM_BYTES(MAX_STREAM_BYTES)) u_front (
    .clk, .rst_n, .in_ch, .cmd, .cmd_valid, .cmd_take
  );

  cdrbg_back #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_back (
    .clk, .rst_n, .cmd, .cmd_valid, .cmd_take, .seed_r, .out_ch
  );
endmodule
